// ----- src/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and codes of the Q24.8 fixed-point unit
// Operation codes, status codes and the record that travels down the chain.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_LT = 4'd4, OP_LE = 4'd5, OP_GT = 4'd6, OP_GE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
	} fpa_op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	// Item record carried beside the divider data.
	typedef struct packed {
		logic        vld;
		logic        is_div;
		logic        neg;
		logic [31:0] res;
		logic        flag;
		logic [1:0]  st;
	} fpa_pass_t;

endpackage
`default_nettype wire

// ----- src/fixed_point_q24_8_alu.sv -----
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu: signed Q24.8 fixed-point arithmetic unit
// Add, subtract, multiply, divide, compare, min/max, step and conversions.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while the skid register is empty
// and returns exactly one result item for each, in order. Every item travels
// the same path: two front stages (operand capture with the 32x32 multiplier,
// then all operations but divide), one division cell per quotient bit (32 +
// FRAC_BITS cells of a restoring divider, each handing its partial remainder
// to the next), and a result register. The length of that cell row sets the
// latency; the rate is one item per cycle for any mix of operations while the
// skid register is empty. A skid register at the output takes one result when
// the sink stalls, so an item is still accepted in that cycle; while the skid
// register is full the whole pipeline holds and s_tready is low. Divide by
// zero gives result 0 and the divide-by-zero status; overflowing results wrap
// and carry the overflow status.
// ----------------------------------------------------------------------------
`default_nettype none
module fixed_point_q24_8_alu #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // [31:0] operand_a, [63:32] operand_b
	input  wire logic [3:0]  s_tuser,  // [3:0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [31:0] result
	output logic [2:0]       m_tuser   // [0] flag, [2:1] status
);
	import fpa_pkg::*;

	localparam int QW = 32 + FRAC_BITS;

	logic      en;
	logic      skid_q;
	fpa_pass_t skid_data_q;
	fpa_pass_t fin_pass;

	// Per-cell hand-off between the division cells.
	fpa_pass_t     pass_w [QW+1];
	logic [31:0]   rem_w  [QW+1];
	logic [QW-1:0] dq_w   [QW+1];
	logic [31:0]   dvs_w  [QW+1];

	// The whole pipeline moves while the skid register is empty.
	assign en       = !skid_q;
	assign s_tready = en;

	fpa_front #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (s_tvalid),
		.op     (s_tuser),
		.a      (s_tdata[31:0]),
		.b      (s_tdata[63:32]),
		.pass_o (pass_w[0]),
		.dvd_o  (dq_w[0]),
		.dvs_o  (dvs_w[0])
	);

	assign rem_w[0] = '0;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		fpa_cell #(.QW(QW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.pass_i (pass_w[i]),
			.rem_i  (rem_w[i]),
			.dq_i   (dq_w[i]),
			.dvs_i  (dvs_w[i]),
			.pass_o (pass_w[i+1]),
			.rem_o  (rem_w[i+1]),
			.dq_o   (dq_w[i+1]),
			.dvs_o  (dvs_w[i+1])
		);
	end

	fpa_fin #(.QW(QW)) u_fin (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.pass_i (pass_w[QW]),
		.quot_i (dq_w[QW]),
		.pass_o (fin_pass)
	);

	// The skid register catches the result that the sink refuses while the
	// pipeline is still moving, and empties once the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (skid_q) begin
			skid_q <= !m_tready;
		end else begin
			skid_q <= fin_pass.vld && !m_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_q) begin
			skid_data_q <= fin_pass;
		end
	end

	assign m_tvalid = skid_q || fin_pass.vld;
	assign m_tdata  = skid_q ? skid_data_q.res : fin_pass.res;
	assign m_tuser  = skid_q ? {skid_data_q.st, skid_data_q.flag}
	                         : {fin_pass.st, fin_pass.flag};

	// The skid register fills only from a result the sink refused.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_q) |-> $past(m_tvalid && !m_tready))
		else $error("skid register filled without a stalled result");

	// A divide by zero always reports a zero result.
	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2:1] == ST_DIV0) |-> (m_tdata == 32'd0))
		else $error("divide by zero with nonzero result");

	// A comparison that is true never reports a non-ok status or a value.
	a_flag_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == ST_OK && m_tdata == 32'd0))
		else $error("comparison flag with status or result");

	// While the skid register holds an item its value stays put.
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_q && $past(skid_q)) |-> $stable(skid_data_q))
		else $error("skid register changed while full");

endmodule
`default_nettype wire

// ----- src/fpa_front.sv -----
// ----------------------------------------------------------------------------
// fpa_front: operand capture, multiplier and all operations but divide
// Stage one registers the operands and the product, stage two finishes all
// operations but divide and prepares the divider operands.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_front #(
	parameter int FRAC_BITS = 8,
	parameter int QW = 32 + FRAC_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_vld,
	input  wire logic [3:0]         op,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output fpa_pkg::fpa_pass_t      pass_o,
	output logic [QW-1:0]           dvd_o,
	output logic [31:0]             dvs_o
);
	import fpa_pkg::*;

	localparam logic signed [31:0] RND32 = 32'((1 << FRAC_BITS) - 1);
	localparam logic signed [63:0] RND64 = 64'((1 << FRAC_BITS) - 1);

	logic               vld_s1;
	logic [3:0]         op_s1;
	logic signed [31:0] a_s1, b_s1;
	logic signed [63:0] prod_s1;

	fpa_pass_t     pass_s2;
	logic [QW-1:0] dvd_s2;
	logic [31:0]   dvs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= op;
			a_s1    <= a;
			b_s1    <= b;
			prod_s1 <= 64'(a) * 64'(b);
		end
	end

	logic signed [32:0]          add_c, sub_c, inc_c, dec_c;
	logic signed [63:0]          mrnd_c, msh_c;
	logic signed [31+FRAC_BITS:0] fi_c;
	logic signed [31:0]          ti_c;
	logic                        lt_c, gt_c, eq_c;
	logic [31:0]                 amag_c, bmag_c;
	fpa_pass_t                   pass_c;

	always_comb begin
		add_c  = 33'(a_s1) + 33'(b_s1);
		sub_c  = 33'(a_s1) - 33'(b_s1);
		inc_c  = 33'(a_s1) + 33'sd1;
		dec_c  = 33'(a_s1) - 33'sd1;
		// Truncation toward zero: bias negative values before the shift.
		mrnd_c = prod_s1 + (prod_s1[63] ? RND64 : 64'sd0);
		msh_c  = mrnd_c >>> FRAC_BITS;
		fi_c   = $signed({a_s1, {FRAC_BITS{1'b0}}});
		ti_c   = (a_s1 + (a_s1[31] ? RND32 : 32'sd0)) >>> FRAC_BITS;
		lt_c   = a_s1 < b_s1;
		gt_c   = a_s1 > b_s1;
		eq_c   = a_s1 == b_s1;
		amag_c = a_s1[31] ? (~a_s1 + 32'd1) : a_s1;
		bmag_c = b_s1[31] ? (~b_s1 + 32'd1) : b_s1;

		pass_c        = '0;
		pass_c.vld    = vld_s1;
		pass_c.neg    = a_s1[31] ^ b_s1[31];
		case (op_s1)
			OP_ADD: begin
				pass_c.res = add_c[31:0];
				pass_c.st  = (add_c[32] != add_c[31]) ? ST_OVF : ST_OK;
			end
			OP_SUB: begin
				pass_c.res = sub_c[31:0];
				pass_c.st  = (sub_c[32] != sub_c[31]) ? ST_OVF : ST_OK;
			end
			OP_MUL: begin
				pass_c.res = msh_c[31:0];
				pass_c.st  = (msh_c[63:31] != {33{msh_c[31]}}) ? ST_OVF : ST_OK;
			end
			OP_DIV: begin
				if (b_s1 == 32'sd0) begin
					pass_c.st = ST_DIV0;
				end else begin
					pass_c.is_div = 1'b1;
				end
			end
			OP_LT: pass_c.flag = lt_c;
			OP_LE: pass_c.flag = lt_c | eq_c;
			OP_GT: pass_c.flag = gt_c;
			OP_GE: pass_c.flag = gt_c | eq_c;
			OP_EQ: pass_c.flag = eq_c;
			OP_NE: pass_c.flag = !eq_c;
			OP_MIN: pass_c.res = lt_c ? a_s1 : b_s1;
			OP_MAX: pass_c.res = gt_c ? a_s1 : b_s1;
			OP_INC: begin
				pass_c.res = inc_c[31:0];
				pass_c.st  = (inc_c[32] != inc_c[31]) ? ST_OVF : ST_OK;
			end
			OP_DEC: begin
				pass_c.res = dec_c[31:0];
				pass_c.st  = (dec_c[32] != dec_c[31]) ? ST_OVF : ST_OK;
			end
			OP_FROM_INT: begin
				pass_c.res = fi_c[31:0];
				pass_c.st  = (fi_c[31+FRAC_BITS:31] != {(FRAC_BITS+1){fi_c[31]}})
				             ? ST_OVF : ST_OK;
			end
			OP_TO_INT: pass_c.res = ti_c;
			default: pass_c.res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_s2 <= '0;
		end else if (en) begin
			pass_s2 <= pass_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s2 <= {amag_c, {FRAC_BITS{1'b0}}};
			dvs_s2 <= bmag_c;
		end
	end

	assign pass_o = pass_s2;
	assign dvd_o  = dvd_s2;
	assign dvs_o  = dvs_s2;

endmodule
`default_nettype wire

// ----- src/fpa_cell.sv -----
// ----------------------------------------------------------------------------
// fpa_cell: one restoring-division step
// Shifts in one dividend bit, subtracts the divisor when it fits and shifts
// the quotient bit into the freed low end of the dividend register.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_cell #(
	parameter int QW = 40
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  fpa_pkg::fpa_pass_t pass_i,
	input  wire logic [31:0]   rem_i,
	input  wire logic [QW-1:0] dq_i,
	input  wire logic [31:0]   dvs_i,
	output fpa_pkg::fpa_pass_t pass_o,
	output logic [31:0]        rem_o,
	output logic [QW-1:0]      dq_o,
	output logic [31:0]        dvs_o
);
	import fpa_pkg::*;

	fpa_pass_t     pass_q;
	logic [31:0]   rem_q, dvs_q;
	logic [QW-1:0] dq_q;
	logic [32:0]   trial_c, diff_c;
	logic          fit_c;

	always_comb begin
		trial_c = {rem_i, dq_i[QW-1]};
		diff_c  = trial_c - {1'b0, dvs_i};
		fit_c   = !diff_c[32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= '0;
		end else if (en) begin
			pass_q <= pass_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// The remainder stays below the divisor, so 32 bits hold it.
			rem_q <= fit_c ? diff_c[31:0] : trial_c[31:0];
			dq_q  <= {dq_i[QW-2:0], fit_c};
			dvs_q <= dvs_i;
		end
	end

	assign pass_o = pass_q;
	assign rem_o  = rem_q;
	assign dq_o   = dq_q;
	assign dvs_o  = dvs_q;

endmodule
`default_nettype wire

// ----- src/fpa_fin.sv -----
// ----------------------------------------------------------------------------
// fpa_fin: quotient sign and range check, result register
// Applies the quotient sign, judges overflow on the exact quotient and
// registers the finished result item.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_fin #(
	parameter int QW = 40
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  fpa_pkg::fpa_pass_t pass_i,
	input  wire logic [QW-1:0] quot_i,
	output fpa_pkg::fpa_pass_t pass_o
);
	import fpa_pkg::*;

	localparam logic [QW-1:0] POS_MAX = QW'(32'h7FFF_FFFF);
	localparam logic [QW-1:0] NEG_MAX = QW'(32'h8000_0000);

	fpa_pass_t pass_q;
	fpa_pass_t pass_c;
	logic      ovf_c;

	always_comb begin
		pass_c = pass_i;
		ovf_c  = pass_i.neg ? (quot_i > NEG_MAX) : (quot_i > POS_MAX);
		if (pass_i.is_div) begin
			pass_c.res = pass_i.neg ? (~quot_i[31:0] + 32'd1) : quot_i[31:0];
			pass_c.st  = ovf_c ? ST_OVF : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= '0;
		end else if (en) begin
			pass_q <= pass_c;
		end
	end

	assign pass_o = pass_q;

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the Q24.8 fixed-point unit
// Directed table of edge cases, then random items under four idling phases,
// each result compared field by field to a typed row or an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module testbench;
	import fpa_pkg::*;

	localparam int FRAC = 8;
	localparam int LAT = 4 + FRAC + 32;

	typedef struct packed {
		logic [31:0] res;
		logic        flag;
		logic [1:0]  st;
	} alu_out_t;

	typedef struct {
		fpa_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
		bit          typed;
		alu_out_t    want;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic [3:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0] m_tuser;

	alu_out_t answers[$];
	int errors = 0;
	int results_seen = 0;
	int send_idle = 0;
	int recv_stall = 0;
	vec_t dir[$];

	fixed_point_q24_8_alu #(.FRAC_BITS(FRAC)) dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Exact 64-bit arithmetic, then wrap and flag overflow when it differs.
	function automatic alu_out_t compute_alu(fpa_op_t op, logic [31:0] ra, logic [31:0] rb);
		longint a, b, x, sc;
		alu_out_t o;
		bit arith;
		a = longint'(signed'(ra));
		b = longint'(signed'(rb));
		sc = longint'(1) << FRAC;
		x = 0;
		o = '0;
		arith = 1;
		case (op)
			OP_ADD: x = a + b;
			OP_SUB: x = a - b;
			OP_MUL: x = (a * b) / sc;
			OP_DIV: begin
				if (b == 0) begin
					arith = 0;
					o.st = ST_DIV0;
				end else x = (a * sc) / b;
			end
			OP_LT: begin o.flag = a < b; arith = 0; end
			OP_LE: begin o.flag = a <= b; arith = 0; end
			OP_GT: begin o.flag = a > b; arith = 0; end
			OP_GE: begin o.flag = a >= b; arith = 0; end
			OP_EQ: begin o.flag = a == b; arith = 0; end
			OP_NE: begin o.flag = a != b; arith = 0; end
			OP_MIN: x = (a < b) ? a : b;
			OP_MAX: x = (a > b) ? a : b;
			OP_INC: x = a + 1;
			OP_DEC: x = a - 1;
			OP_FROM_INT: x = a * sc;
			default: x = a / sc;
		endcase
		if (arith && (x > 64'sd2147483647 || x < -64'sd2147483648)) o.st = ST_OVF;
		o.res = x[31:0];
		return o;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 1) ? $urandom_range(0, 1024)
				: -$urandom_range(0, 1024);
			3: return {{16{1'b0}}, 16'($urandom)} ^ ($urandom_range(0, 1) ? '1 : '0);
			default: return $urandom;
		endcase
	endfunction

	// The valid line drops only while the sender idles, so back-to-back items
	// never see two assignments to it in one time step.
	task automatic send_item(fpa_op_t op, logic [31:0] a, logic [31:0] b);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {b, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic add_row(fpa_op_t op, logic [31:0] a, logic [31:0] b, bit typed,
			logic [31:0] res, logic flag, logic [1:0] st);
		vec_t v;
		v.op = op; v.a = a; v.b = b; v.typed = typed;
		v.want = '{res: res, flag: flag, st: st};
		dir.push_back(v);
	endtask

	// Receiver: random stalls, then checking at the accepting edge.
	always @(posedge clk) begin
		alu_out_t got, exp_o;
		m_tready <= ($urandom_range(0, 99) >= recv_stall);
		if (m_tvalid && m_tready) begin
			got = '{res: m_tdata, flag: m_tuser[0], st: m_tuser[2:1]};
			results_seen++;
			if (answers.size() == 0) begin
				$error("result with nothing expected: %h", got);
				errors++;
			end else begin
				exp_o = answers.pop_front();
				if (got.res !== exp_o.res) begin
					$error("result expected %h actual %h", exp_o.res, got.res);
					errors++;
				end
				if (got.flag !== exp_o.flag) begin
					$error("flag expected %b actual %b", exp_o.flag, got.flag);
					errors++;
				end
				if (got.st !== exp_o.st) begin
					$error("status expected %0d actual %0d", exp_o.st, got.st);
					errors++;
				end
			end
		end
	end

	initial begin
		#100000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		fpa_op_t op;
		logic [31:0] a, b;
		int n;
		// Directed rows; typed ones carry results readable at a glance.
		add_row(OP_ADD, 32'h7FFF_FFFF, 32'd1, 1, 32'h8000_0000, 0, ST_OVF);
		add_row(OP_SUB, 32'h8000_0000, 32'd1, 1, 32'h7FFF_FFFF, 0, ST_OVF);
		add_row(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
		add_row(OP_MUL, 32'h0000_0100, 32'hFFFF_FF00, 1, 32'hFFFF_FF00, 0, ST_OK);
		add_row(OP_DIV, 32'h1234_5678, 32'd0, 1, 32'd0, 0, ST_DIV0);
		add_row(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0);
		add_row(OP_DIV, 32'hFFFF_FF01, 32'h0000_0200, 0, 0, 0, 0);
		add_row(OP_LT, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'd0, 1, ST_OK);
		add_row(OP_LE, 32'd5, 32'd5, 1, 32'd0, 1, ST_OK);
		add_row(OP_GT, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'd0, 0, ST_OK);
		add_row(OP_GE, 32'd5, 32'd5, 1, 32'd0, 1, ST_OK);
		add_row(OP_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, 1, ST_OK);
		add_row(OP_NE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, 0, ST_OK);
		add_row(OP_MIN, 32'd7, 32'd7, 1, 32'd7, 0, ST_OK);
		add_row(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0, ST_OK);
		add_row(OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 32'h8000_0000, 0, ST_OVF);
		add_row(OP_DEC, 32'h8000_0000, 32'd0, 1, 32'h7FFF_FFFF, 0, ST_OVF);
		add_row(OP_FROM_INT, 32'h007F_FFFF, 32'd0, 1, 32'h7FFF_FF00, 0, ST_OK);
		add_row(OP_FROM_INT, 32'hFF80_0000, 32'd0, 1, 32'h8000_0000, 0, ST_OK);
		add_row(OP_FROM_INT, 32'h0080_0000, 32'd0, 1, 32'h8000_0000, 0, ST_OVF);
		add_row(OP_TO_INT, 32'hFFFF_FF01, 32'd0, 1, 32'd0, 0, ST_OK);
		add_row(OP_TO_INT, 32'h8000_0000, 32'd0, 1, 32'hFF80_0000, 0, ST_OK);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[i]) begin
			answers.push_back(dir[i].typed ? dir[i].want
				: compute_alu(dir[i].op, dir[i].a, dir[i].b));
			send_item(dir[i].op, dir[i].a, dir[i].b);
		end

		// Random part: four idling phases of 480 items each.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 86; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 86; end
				default: begin send_idle = 6; recv_stall = 6; end
			endcase
			n = 480;
			repeat (n) begin
				op = fpa_op_t'($urandom_range(0, 15));
				a = rand_operand();
				b = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_operand();
				answers.push_back(compute_alu(op, a, b));
				send_item(op, a, b);
			end
		end
		s_tvalid <= 1'b0;

		recv_stall = 0;
		while (answers.size() != 0) @(posedge clk);
		repeat (LAT * 2) @(posedge clk);
		$display("Covered %0d results: every operation, overflow, divide by zero,",
			results_seen);
		$display("operand extremes, and four sender/receiver idling phases.");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- fixed_point_q24_8_alu.f -----
src/fpa_pkg.sv
src/fpa_front.sv
src/fpa_cell.sv
src/fpa_fin.sv
src/fixed_point_q24_8_alu.sv
test/testbench.sv
